/* hw/rtl/sitoa_pkg.sv */
// shared constants, types and state encodings for the signed integer to ascii core
package sitoa_pkg;

  // operand width, sign in the top bit
  localparam int VALUE_WIDTH = 32;

  // decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1)
  localparam int NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int IDX_W = $clog2(NDIG);

  // double dabble consumes this many bits per cycle
  localparam int STEP_BITS = 4;
  localparam int STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W = STEPS * STEP_BITS;
  localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // ascii codes
  localparam logic [6:0] CHAR_MINUS = 7'd45;
  localparam logic [6:0] CHAR_ZERO = 7'd48;

  typedef logic [3:0] digit_t;

  // one converted number waiting for output
  typedef struct packed {
    logic                    neg;
    digit_t [NDIG-1:0]       digits;
    logic [IDX_W-1:0]        top;
  } q_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_DONE
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

endpackage

/* hw/rtl/sitoa_front.sv */
// front end: accepts a value, takes its magnitude and converts it to bcd
module sitoa_front import sitoa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   busy,
  output logic                   push,
  output q_entry_t               push_data,
  input  logic                   q_full
);

  front_state_t            state_r, state_nxt;
  logic [STEP_CNT_W-1:0]   step_r, step_nxt;
  logic                    neg_r, neg_nxt;
  logic [PAD_W-1:0]        bin_r, bin_nxt;
  digit_t [NDIG-1:0]       bcd_r, bcd_nxt;
  logic [VALUE_WIDTH-1:0]  mag;
  logic [IDX_W-1:0]        top_idx;

  // several double dabble bit steps in one cycle
  function automatic logic [NDIG*4+PAD_W-1:0] dabble(digit_t [NDIG-1:0] bcd,
                                                     logic [PAD_W-1:0] bin);
    digit_t [NDIG-1:0] bcd_v;
    logic [PAD_W-1:0]  bin_v;
    bcd_v = bcd;
    bin_v = bin;
    for (int s = 0; s < STEP_BITS; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_v[d] >= 4'd5) begin
          bcd_v[d] = bcd_v[d] + 4'd3;
        end
      end
      {bcd_v, bin_v} = {bcd_v, bin_v} << 1;
    end
    return {bcd_v, bin_v};
  endfunction

  // magnitude as unsigned, exact for the most negative value
  assign mag = in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;

  assign busy = (state_r != F_IDLE);

  // index of the highest nonzero digit, zero for a zero value
  always_comb begin
    top_idx = '0;
    for (int d = 1; d < NDIG; d++) begin
      if (bcd_r[d] != 4'd0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  assign push_data = '{neg: neg_r, digits: bcd_r, top: top_idx};

  // next state and conversion steps
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    push      = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (start) begin
          neg_nxt   = in_value[VALUE_WIDTH-1];
          bin_nxt   = PAD_W'(mag);
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        {bcd_nxt, bin_nxt} = dabble(bcd_r, bin_r);
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_CNT_W'(STEPS - 1)) begin
          state_nxt = F_DONE;
        end
      end
      F_DONE: begin
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
  end

endmodule

/* hw/rtl/sitoa_queue.sv */
// small fifo of converted numbers between front and back
module sitoa_queue import sitoa_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  output logic     full,
  input  logic     pop,
  output q_entry_t pop_data,
  output logic     empty
);

  q_entry_t             mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0]   count_r;

  assign full     = (count_r == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hw/rtl/sitoa_back.sv */
// back end: emits sign and digits, one character per cycle, msd first
module sitoa_back import sitoa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  q_entry_t   q_data,
  output logic       q_pop,
  output logic       out_valid,
  output logic [6:0] out_character,
  output logic       out_last
);

  back_state_t        state_r, state_nxt;
  logic               minus_r, minus_nxt;
  digit_t [NDIG-1:0]  digits_r, digits_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  digit_t             cur_digit;
  logic               is_last;
  logic               load;

  assign cur_digit = digits_r[idx_r];
  assign is_last   = !minus_r && (idx_r == '0);

  // character output
  assign out_valid     = (state_r == B_EMIT);
  assign out_character = minus_r ? CHAR_MINUS : (CHAR_ZERO + {3'b000, cur_digit});
  assign out_last      = is_last;

  // take the next number when idle or on the final character
  assign load  = ((state_r == B_IDLE) || is_last) && !q_empty;
  assign q_pop = load;

  // next state and character sequencing
  always_comb begin
    state_nxt  = state_r;
    minus_nxt  = minus_r;
    digits_nxt = digits_r;
    idx_nxt    = idx_r;
    unique case (state_r)
      B_IDLE: begin
        if (load) begin
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (minus_r) begin
          minus_nxt = 1'b0;
        end else if (idx_r != '0) begin
          idx_nxt = idx_r - 1'b1;
        end else if (!load) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    if (load) begin
      minus_nxt  = q_data.neg;
      digits_nxt = q_data.digits;
      idx_nxt    = q_data.top;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // character data registers
  always_ff @(posedge clk) begin
    minus_r  <= minus_nxt;
    digits_r <= digits_nxt;
    idx_r    <= idx_nxt;
  end

endmodule

/* hw/rtl/signed_int_to_decimal_ascii_core.sv */
// top level: signed integer to decimal ascii, front converter, queue and emitter
// first character leaves after the front's conversion steps, its push into the queue and the back's load
// front converts four bits per cycle and takes a new value only once it has pushed the last one
// back emits one character per cycle, up to 11 per number, so sustained throughput is set by
// the slower of the converter loop and the character count
// synchronous active-low reset empties the queue and idles both sides; no stall on output
module signed_int_to_decimal_ascii_core import sitoa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  output logic [6:0]             out_character,
  output logic                   out_last
);

  logic     push, q_full, q_pop, q_empty;
  q_entry_t push_data, pop_data;

  // conversion front end
  sitoa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_value  (in_value),
    .busy      (busy),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // decoupling queue
  sitoa_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // character emitter
  sitoa_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

/* hw/rtl/sitoa_checker.sv */
// port-level assertions for the signed integer to ascii core, with bind
module sitoa_checker import sitoa_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [6:0] out_character,
  input logic       out_last
);

  // only minus sign or decimal digits leave the block
  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_character == CHAR_MINUS) ||
                  ((out_character >= CHAR_ZERO) && (out_character <= CHAR_ZERO + 7'd9)))
    else $error("bad character code");

  // a minus sign is followed at once by a leading digit other than zero
  a_minus_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_character == CHAR_MINUS)) |->
      !out_last ##1 (out_valid && (out_character != CHAR_MINUS) &&
                     (out_character != CHAR_ZERO)))
    else $error("minus sign not followed by a leading digit");

  // an accepted transaction keeps the front end busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // reset leaves both sides idle
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("not idle after reset");

  // the last flag never sits on a minus sign
  a_last_not_minus: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_character != CHAR_MINUS))
    else $error("last flag on minus sign");

endmodule

bind signed_int_to_decimal_ascii_core sitoa_checker u_sitoa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_character (out_character),
  .out_last      (out_last)
);

/* verif/signed_int_to_decimal_ascii_core_tb.sv */
// testbench for the signed integer to decimal ascii core: directed and random values, text check
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_core_tb;
  import sitoa_pkg::*;

  // one expected output character
  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } ascii_char_t;

  // one value waiting to be sent, optionally only once the core has drained
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   drain_first;
  } pending_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [VALUE_WIDTH-1:0] in_value = '0;
  logic                   out_valid;
  logic [6:0]             out_character;
  logic                   out_last;

  pending_t    value_q[$];
  ascii_char_t text_q[$];
  int          errors = 0;
  int          sent_cnt = 0;

  signed_int_to_decimal_ascii_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // expected decimal text of one accepted value, sign first, then digits msd first
  function automatic void predict_text(input logic [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH:0] mag;
    logic                 neg;
    logic [3:0]           digs[24];
    int                   nd;
    ascii_char_t          c;
    neg = v[VALUE_WIDTH-1];
    mag = neg ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    mag[VALUE_WIDTH] = 1'b0;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      c.code = CHAR_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.code = CHAR_ZERO + 7'(digs[i]);
      c.last = (i == 0);
      text_q.push_back(c);
    end
  endfunction

  // random value: full range, small, random digit count, or next to a power of ten
  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    longint mag;
    longint p;
    int     k;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: mag = $urandom_range(0, 999);
      2: begin
        k = $urandom_range(1, 10);
        p = 1;
        repeat (k) p = p * 10;
        mag = longint'($urandom) % p;
      end
      default: begin
        k = $urandom_range(0, 9);
        p = 1;
        repeat (k) p = p * 10;
        mag = p + $urandom_range(0, 2) - 1;
      end
    endcase
    if ($urandom_range(0, 1)) mag = -mag;
    return 32'(mag);
  endfunction

  function automatic void queue_value(input logic [VALUE_WIDTH-1:0] v, input logic drain);
    pending_t p;
    p.value = v;
    p.drain_first = drain;
    value_q.push_back(p);
  endfunction

  // driver: present the next value, hold it until the core takes it
  always @(posedge clk) begin : drive
    logic     took;
    logic     calm;
    pending_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) sent_cnt++;
      calm = (sent_cnt >= 200) && (sent_cnt < 300);
      if (start && !took) begin
        // still waiting for the core to take the current transaction
      end else if (value_q.size() == 0) begin
        start <= 1'b0;
      end else if (value_q[0].drain_first && (took || text_q.size() != 0)) begin
        start <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 11) begin
        start <= 1'b0;
      end else begin
        nxt = value_q.pop_front();
        start <= 1'b1;
        in_value <= nxt.value;
      end
    end
  end

  // monitor: check each output character, then record the text of an accepted transaction
  always @(posedge clk) begin : watch
    ascii_char_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (text_q.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual %0d last %0b",
                   $time, out_character, out_last);
          errors++;
        end else begin
          want = text_q.pop_front();
          if (out_character !== want.code) begin
            $display("%0t: character mismatch: expected %0d, actual %0d",
                     $time, want.code, out_character);
            errors++;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b",
                     $time, want.last, out_last);
            errors++;
          end
        end
      end
      if (start && !busy) predict_text(in_value);
    end
  end

  // stimulus and end of run
  initial begin
    // directed: zero, one digit, digit count edges, extremes, bit patterns
    queue_value(32'd0, 1'b0);
    queue_value(32'd1, 1'b0);
    queue_value(-32'sd1, 1'b0);
    queue_value(32'd9, 1'b0);
    queue_value(32'd10, 1'b0);
    queue_value(-32'sd9, 1'b0);
    queue_value(-32'sd10, 1'b0);
    queue_value(32'd99, 1'b0);
    queue_value(32'd100, 1'b0);
    queue_value(32'd12345, 1'b0);
    queue_value(32'h7FFF_FFFF, 1'b0);
    queue_value(32'h8000_0000, 1'b1);
    queue_value(32'h8000_0001, 1'b0);
    queue_value(32'd999_999_999, 1'b0);
    queue_value(32'd1_000_000_000, 1'b0);
    queue_value(-32'sd1_000_000_000, 1'b0);
    queue_value(32'd1_000_000_001, 1'b0);
    queue_value(32'h5555_5555, 1'b0);
    queue_value(32'hAAAA_AAAA, 1'b0);
    queue_value(32'd0, 1'b0);
    queue_value(32'h8000_0000, 1'b0);
    queue_value(32'd7, 1'b0);
    // random part, with a few drain pauses spread through it
    for (int n = 0; n < 450; n++) begin
      queue_value(pick_value(), (n % 97) == 50);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (value_q.size() != 0 || start || text_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    // characters still owed at the end are lost output
    if (text_q.size() != 0) begin
      $display("%0t: missing characters: expected %0d more, actual none",
               $time, text_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
